>>> rtl/trqs_pkg.sv
`timescale 1ns / 1ps
package trqs_pkg;

  // command kinds
  localparam logic [2:0] K_TICK   = 3'd0;
  localparam logic [2:0] K_YIELD  = 3'd1;
  localparam logic [2:0] K_EXITC  = 3'd2;
  localparam logic [2:0] K_DELAY  = 3'd3;
  localparam logic [2:0] K_WAIT   = 3'd4;
  localparam logic [2:0] K_NOTIFY = 3'd5;
  localparam logic [2:0] K_RUN    = 3'd6;
  localparam logic [2:0] K_EXITT  = 3'd7;

  // list membership codes
  localparam logic [1:0] M_FREE = 2'd0;
  localparam logic [1:0] M_RUN  = 2'd1;
  localparam logic [1:0] M_EVT  = 2'd2;
  localparam logic [1:0] M_TMR  = 2'd3;

  localparam int unsigned DEF_TASK_COUNT  = 16;
  localparam int unsigned DEF_EVENT_COUNT = 16;
  localparam int unsigned DEF_MS_PER_TICK = 10;

  typedef enum logic [2:0] {
    OP_NOP,
    OP_PUSH,
    OP_INSERT,
    OP_REMOVE,
    OP_POP,
    OP_PART
  } trqs_op_t;

  typedef struct packed {
    trqs_op_t op;
    logic     phase;
  } trqs_ctl_t;

  // remainder of a 4-bit value by a small modulus, binary long division
  function automatic logic [3:0] trqs_mod16(input logic [3:0] v, input int unsigned m);
    logic [9:0] r;
    r = {6'b0, v};
    for (int k = 3; k >= 0; k--) begin
      if (r >= 10'(m << k)) begin
        r = r - 10'(m << k);
      end
    end
    return r[3:0];
  endfunction

endpackage

>>> rtl/task_run_queue_scheduler.sv
`timescale 1ns / 1ps
// task run-queue scheduler
// input channel (in_valid / in_stall): one command transaction carrying kind, task_id,
//   delay_ms and event_id; in_stall is high while a command is being worked on
// output channel (out_valid / out_stall): one result transaction per command with
//   current_task, accepted and tick_count, held in an output register so the next
//   command is taken while a result still waits
// config channel (cfg_valid / cfg_ready): writes fallback_task, always ready; the user
//   must write it only while idle, which the block itself does not enforce
// states (S_*) per command, from acceptance to result valid:
//   run task, exit of a non-current task: EXEC, DONE
//   tick, yield, exit current, wait event, exit task of current: EXEC, DROP, PICK, DONE
//   delay current: DIV (times the reciprocal of MS_PER_TICK), then EXEC, DROP, PICK, DONE
//   notify: EXEC, PART (odd-even passes over the event-list cells), DONE
// a new command can be taken in the cycle after the previous result is loaded; commands do not overlap
// the three lists are chains of cells that shift one place per cycle
// reset (rst, synchronous): all lists empty, flags clear, ticks zero, current is task 0
// a stalled result holds; a finished command waits until the output register frees
module task_run_queue_scheduler #(
  parameter int unsigned TASK_COUNT  = trqs_pkg::DEF_TASK_COUNT,
  parameter int unsigned EVENT_COUNT = trqs_pkg::DEF_EVENT_COUNT,
  parameter int unsigned MS_PER_TICK = trqs_pkg::DEF_MS_PER_TICK
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [3:0]  fallback_task,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  kind,
  input  logic [3:0]  task_id,
  input  logic [31:0] delay_ms,
  input  logic [3:0]  event_id,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [3:0]  current_task,
  output logic        accepted,
  output logic [63:0] tick_count
);
  import trqs_pkg::*;

  localparam int unsigned ID_W  = $clog2(TASK_COUNT);
  localparam int unsigned EV_W  = (EVENT_COUNT > 1) ? $clog2(EVENT_COUNT) : 1;
  localparam int unsigned PC_W  = $clog2(TASK_COUNT);
  // fixed-point reciprocal, exact for every 32-bit delay
  localparam int unsigned RSH   = 32 + $clog2(MS_PER_TICK);
  localparam logic [32:0] RECIP = 33'(((64'd1 << RSH) + 64'(MS_PER_TICK) - 64'd1)
                                      / 64'(MS_PER_TICK));

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV,
    S_EXEC,
    S_DROP,
    S_PICK,
    S_PART,
    S_DONE
  } state_t;

  state_t st;

  // registers
  logic [3:0]      idle_reg;
  logic [ID_W-1:0] cur;
  logic [63:0]     ticks;
  logic [1:0]      memb [TASK_COUNT];
  logic [EVENT_COUNT-1:0] flags;
  logic [2:0]      kind_r;
  logic [3:0]      tid_raw;
  logic [EV_W-1:0] ev;
  logic [31:0]     dq;
  logic [64:0]     prod;
  logic            div_cnt;
  logic [PC_W-1:0] part_cnt;
  logic [63:0]     wake;
  logic            acc;

  // derived command fields
  logic [ID_W-1:0] idle_id;
  logic [ID_W-1:0] tid;
  logic            tid_ok;
  logic            run_ok;
  logic            req_exit;
  logic            cur_busy;

  // reciprocal multiply, one 16-bit half of the delay per cycle
  logic [15:0]     mul_in;
  logic [48:0]     part;
  logic [31:0]     quot;

  // list chains
  trqs_ctl_t       run_ctl, evt_ctl, tmr_ctl;
  logic [ID_W-1:0] run_id, evt_id, tmr_id;
  logic [0:0]      run_key;
  logic [EV_W-1:0] evt_key;
  logic [63:0]     tmr_key;
  logic            run_hv, evt_hv, tmr_hv;
  logic [ID_W-1:0] run_hid, evt_hid, tmr_hid;
  logic [0:0]      run_hk;
  logic [EV_W-1:0] evt_hk;
  logic [63:0]     tmr_hk;

  logic            ev_ready, tmr_ready;
  logic            do_rm;
  logic [ID_W-1:0] rm_id;
  logic [1:0]      rm_list;

  assign cfg_ready = 1'b1;
  assign in_stall  = (st != S_IDLE);

  assign idle_id  = ID_W'(trqs_mod16(idle_reg, TASK_COUNT));
  assign tid      = ID_W'(tid_raw);
  assign tid_ok   = (int'(tid_raw) < TASK_COUNT);
  assign run_ok   = tid_ok && (tid != cur) && (memb[tid] == M_FREE);
  assign req_exit = (kind_r == K_EXITC) || (kind_r == K_EXITT);
  assign cur_busy = (cur != idle_id);

  assign mul_in = div_cnt ? dq[31:16] : dq[15:0];
  assign part   = 49'(mul_in) * 49'(RECIP);
  assign quot   = 32'(prod >> RSH);

  assign ev_ready  = evt_hv && flags[evt_hk];
  assign tmr_ready = tmr_hv && (ticks >= tmr_hk);

  // unlink: a queued task other than current on exit task, or a queued current (not the idle task) on exit
  assign rm_id   = (st == S_DROP) ? cur : tid;
  assign rm_list = memb[rm_id];
  assign do_rm   = ((st == S_EXEC) && (kind_r == K_EXITT) && tid_ok && (tid != cur)
                    && (memb[tid] != M_FREE))
                || ((st == S_DROP) && cur_busy && (memb[cur] != M_FREE) && req_exit);

  always_comb begin
    run_ctl = '{op: OP_NOP, phase: 1'b0};
    evt_ctl = '{op: OP_NOP, phase: 1'b0};
    tmr_ctl = '{op: OP_NOP, phase: 1'b0};
    run_id  = rm_id;
    evt_id  = rm_id;
    tmr_id  = rm_id;
    run_key = 1'b0;
    evt_key = ev;
    tmr_key = wake;
    if (do_rm) begin
      case (rm_list)
        M_RUN:   run_ctl.op = OP_REMOVE;
        M_EVT:   evt_ctl.op = OP_REMOVE;
        M_TMR:   tmr_ctl.op = OP_REMOVE;
        default: run_ctl.op = OP_NOP;
      endcase
    end
    case (st)
      S_EXEC: begin
        if ((kind_r == K_RUN) && run_ok) begin
          run_ctl.op = OP_PUSH;
          run_id     = tid;
        end
      end
      S_DROP: begin
        if (cur_busy && (memb[cur] == M_FREE) && !req_exit) begin
          case (kind_r)
            K_DELAY: begin
              tmr_ctl.op = OP_INSERT;
              tmr_id     = cur;
            end
            K_WAIT: begin
              evt_ctl.op = OP_PUSH;
              evt_id     = cur;
            end
            default: begin
              run_ctl.op = OP_PUSH;
              run_id     = cur;
            end
          endcase
        end
      end
      S_PICK: begin
        if (ev_ready) begin
          evt_ctl.op = OP_POP;
        end else if (tmr_ready) begin
          tmr_ctl.op = OP_POP;
        end else if (run_hv) begin
          run_ctl.op = OP_POP;
        end
      end
      S_PART: begin
        evt_ctl = '{op: OP_PART, phase: part_cnt[0]};
      end
      default: begin
        evt_key = ev;
      end
    endcase
  end

  trqs_chain #(.CELLS(TASK_COUNT), .ID_W(ID_W), .KEY_W(1)) u_run (
    .clk(clk), .rst(rst), .ctl(run_ctl), .new_id(run_id), .new_key(run_key),
    .head_valid(run_hv), .head_id(run_hid), .head_key(run_hk)
  );

  trqs_chain #(.CELLS(TASK_COUNT), .ID_W(ID_W), .KEY_W(EV_W)) u_evt (
    .clk(clk), .rst(rst), .ctl(evt_ctl), .new_id(evt_id), .new_key(evt_key),
    .head_valid(evt_hv), .head_id(evt_hid), .head_key(evt_hk)
  );

  trqs_chain #(.CELLS(TASK_COUNT), .ID_W(ID_W), .KEY_W(64)) u_tmr (
    .clk(clk), .rst(rst), .ctl(tmr_ctl), .new_id(tmr_id), .new_key(tmr_key),
    .head_valid(tmr_hv), .head_id(tmr_hid), .head_key(tmr_hk)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      st        <= S_IDLE;
      out_valid <= 1'b0;
      idle_reg  <= '0;
      cur       <= '0;
      ticks     <= '0;
      flags     <= '0;
      for (int i = 0; i < TASK_COUNT; i++) begin
        memb[i] <= M_FREE;
      end
    end else begin
      if (cfg_valid && cfg_ready) begin
        idle_reg <= fallback_task;
      end
      // a result loaded in S_DONE keeps out_valid high
      if (out_valid && !out_stall && (st != S_DONE)) begin
        out_valid <= 1'b0;
      end
      case (st)
        S_IDLE: begin
          if (in_valid) begin
            kind_r  <= kind;
            tid_raw <= task_id;
            ev      <= EV_W'(trqs_mod16(event_id, EVENT_COUNT));
            dq      <= delay_ms;
            div_cnt <= 1'b0;
            acc     <= 1'b0;
            if (kind == K_TICK) begin
              ticks <= ticks + 64'd1;
            end
            st <= (kind == K_DELAY) ? S_DIV : S_EXEC;
          end
        end
        S_DIV: begin
          // low half first, then the high half shifted up by 16
          prod    <= div_cnt ? (prod + {part, 16'b0}) : 65'(part);
          div_cnt <= 1'b1;
          if (div_cnt) begin
            st <= S_EXEC;
          end
        end
        S_EXEC: begin
          case (kind_r)
            K_NOTIFY: begin
              flags[ev] <= 1'b1;
              part_cnt  <= '0;
              st        <= S_PART;
            end
            K_RUN: begin
              if (run_ok) begin
                memb[tid] <= M_RUN;
                acc       <= 1'b1;
              end
              st <= S_DONE;
            end
            K_EXITT: begin
              if (tid_ok && (tid == cur)) begin
                st <= S_DROP;
              end else begin
                if (do_rm) begin
                  memb[tid] <= M_FREE;
                end
                st <= S_DONE;
              end
            end
            K_DELAY: begin
              wake <= ticks + {32'b0, quot};
              st   <= S_DROP;
            end
            default: begin
              st <= S_DROP;
            end
          endcase
        end
        S_DROP: begin
          if (cur_busy) begin
            if (memb[cur] != M_FREE) begin
              if (req_exit) begin
                memb[cur] <= M_FREE;
              end
            end else if (!req_exit) begin
              case (kind_r)
                K_DELAY: memb[cur] <= M_TMR;
                K_WAIT:  memb[cur] <= M_EVT;
                default: memb[cur] <= M_RUN;
              endcase
            end
          end
          st <= S_PICK;
        end
        S_PICK: begin
          if (ev_ready) begin
            cur           <= evt_hid;
            memb[evt_hid] <= M_FREE;
          end else if (tmr_ready) begin
            cur           <= tmr_hid;
            memb[tmr_hid] <= M_FREE;
          end else if (run_hv) begin
            cur           <= run_hid;
            memb[run_hid] <= M_FREE;
          end else begin
            cur <= idle_id;
          end
          st <= S_DONE;
        end
        S_PART: begin
          part_cnt <= part_cnt + PC_W'(1);
          if (part_cnt == PC_W'(TASK_COUNT - 1)) begin
            st <= S_DONE;
          end
        end
        S_DONE: begin
          if (!out_valid || !out_stall) begin
            current_task <= 4'(cur);
            accepted     <= acc;
            tick_count   <= ticks;
            out_valid    <= 1'b1;
            st           <= S_IDLE;
          end
        end
        default: begin
          st <= S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_run_head_member: assert property (@(posedge clk) disable iff (rst)
    run_hv |-> memb[run_hid] == M_RUN)
    else $error("run list head not marked runnable");

  a_evt_head_member: assert property (@(posedge clk) disable iff (rst)
    evt_hv |-> memb[evt_hid] == M_EVT)
    else $error("event list head not marked waiting on event");

  a_tmr_head_member: assert property (@(posedge clk) disable iff (rst)
    tmr_hv |-> memb[tmr_hid] == M_TMR)
    else $error("timer list head not marked waiting on timer");

  a_tick_count: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall && kind == K_TICK) |=> ticks == $past(ticks) + 64'd1)
    else $error("tick command did not advance the tick count");

  a_acc_run_only: assert property (@(posedge clk) disable iff (rst)
    (st == S_DONE && acc) |-> kind_r == K_RUN)
    else $error("accepted flag set for a command other than run task");

  a_run_key_zero: assert property (@(posedge clk) disable iff (rst)
    run_hv |-> run_hk == 1'b0)
    else $error("run list entry carries a key");
`endif

endmodule

>>> rtl/trqs_cell.sv
`timescale 1ns / 1ps
module trqs_cell #(
  parameter int unsigned ID_W  = 4,
  parameter int unsigned KEY_W = 4
) (
  input  logic               clk,
  input  logic               rst,
  input  trqs_pkg::trqs_ctl_t ctl,
  input  logic [ID_W-1:0]    new_id,
  input  logic [KEY_W-1:0]   new_key,
  input  logic               odd,
  input  logic               l_valid,
  input  logic [ID_W-1:0]    l_id,
  input  logic [KEY_W-1:0]   l_key,
  input  logic               l_gt,
  input  logic               l_seen,
  input  logic               l_m,
  input  logic               r_valid,
  input  logic [ID_W-1:0]    r_id,
  input  logic [KEY_W-1:0]   r_key,
  input  logic               r_m,
  output logic               valid,
  output logic [ID_W-1:0]    id,
  output logic [KEY_W-1:0]   key,
  output logic               gt,
  output logic               seen,
  output logic               m
);
  import trqs_pkg::*;

  logic             valid_next;
  logic [ID_W-1:0]  id_next;
  logic [KEY_W-1:0] key_next;

  assign m    = valid && (key == new_key);
  assign gt   = !valid || (key > new_key);
  assign seen = l_seen || (valid && (id == new_id));

  always_comb begin
    valid_next = valid;
    id_next    = id;
    key_next   = key;
    case (ctl.op)
      OP_PUSH: begin
        if (!valid && l_valid) begin
          valid_next = 1'b1;
          id_next    = new_id;
          key_next   = new_key;
        end
      end
      OP_INSERT: begin
        if (l_gt) begin
          valid_next = l_valid;
          id_next    = l_id;
          key_next   = l_key;
        end else if (gt) begin
          valid_next = 1'b1;
          id_next    = new_id;
          key_next   = new_key;
        end
      end
      OP_REMOVE: begin
        if (seen) begin
          valid_next = r_valid;
          id_next    = r_id;
          key_next   = r_key;
        end
      end
      OP_POP: begin
        valid_next = r_valid;
        id_next    = r_id;
        key_next   = r_key;
      end
      OP_PART: begin
        // odd-even transposition: matching entries bubble toward the head
        if ((odd == ctl.phase) && valid && r_valid && !m && r_m) begin
          id_next  = r_id;
          key_next = r_key;
        end else if ((odd != ctl.phase) && l_valid && valid && !l_m && m) begin
          id_next  = l_id;
          key_next = l_key;
        end
      end
      default: begin
        valid_next = valid;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= valid_next;
    end
    id  <= id_next;
    key <= key_next;
  end

endmodule

>>> rtl/trqs_chain.sv
`timescale 1ns / 1ps
module trqs_chain #(
  parameter int unsigned CELLS = 16,
  parameter int unsigned ID_W  = 4,
  parameter int unsigned KEY_W = 4
) (
  input  logic                clk,
  input  logic                rst,
  input  trqs_pkg::trqs_ctl_t ctl,
  input  logic [ID_W-1:0]     new_id,
  input  logic [KEY_W-1:0]    new_key,
  output logic                head_valid,
  output logic [ID_W-1:0]     head_id,
  output logic [KEY_W-1:0]    head_key
);
  import trqs_pkg::*;

  logic             v  [CELLS];
  logic [ID_W-1:0]  id [CELLS];
  logic [KEY_W-1:0] ky [CELLS];
  logic             gt [CELLS];
  logic             sn [CELLS];
  logic             mt [CELLS];

  logic             lv [CELLS];
  logic [ID_W-1:0]  li [CELLS];
  logic [KEY_W-1:0] lk [CELLS];
  logic             lg [CELLS];
  logic             ls [CELLS];
  logic             lm [CELLS];
  logic             rv [CELLS];
  logic [ID_W-1:0]  ri [CELLS];
  logic [KEY_W-1:0] rk [CELLS];
  logic             rm [CELLS];

  for (genvar i = 0; i < CELLS; i++) begin : g_cell
    if (i == 0) begin : g_lb
      assign lv[i] = 1'b1;
      assign li[i] = '0;
      assign lk[i] = '0;
      assign lg[i] = 1'b0;
      assign ls[i] = 1'b0;
      assign lm[i] = 1'b1;
    end else begin : g_ln
      assign lv[i] = v[i-1];
      assign li[i] = id[i-1];
      assign lk[i] = ky[i-1];
      assign lg[i] = gt[i-1];
      assign ls[i] = sn[i-1];
      assign lm[i] = mt[i-1];
    end
    if (i == CELLS - 1) begin : g_rb
      assign rv[i] = 1'b0;
      assign ri[i] = '0;
      assign rk[i] = '0;
      assign rm[i] = 1'b0;
    end else begin : g_rn
      assign rv[i] = v[i+1];
      assign ri[i] = id[i+1];
      assign rk[i] = ky[i+1];
      assign rm[i] = mt[i+1];
    end

    trqs_cell #(
      .ID_W (ID_W),
      .KEY_W(KEY_W)
    ) u_cell (
      .clk    (clk),
      .rst    (rst),
      .ctl    (ctl),
      .new_id (new_id),
      .new_key(new_key),
      .odd    (1'(i % 2)),
      .l_valid(lv[i]),
      .l_id   (li[i]),
      .l_key  (lk[i]),
      .l_gt   (lg[i]),
      .l_seen (ls[i]),
      .l_m    (lm[i]),
      .r_valid(rv[i]),
      .r_id   (ri[i]),
      .r_key  (rk[i]),
      .r_m    (rm[i]),
      .valid  (v[i]),
      .id     (id[i]),
      .key    (ky[i]),
      .gt     (gt[i]),
      .seen   (sn[i]),
      .m      (mt[i])
    );
  end

  assign head_valid = v[0];
  assign head_id    = id[0];
  assign head_key   = ky[0];

endmodule

>>> tb/tb_task_run_queue_scheduler.sv
`timescale 1ns / 1ps
module tb_task_run_queue_scheduler;
  import trqs_pkg::*;

  localparam int NTASK    = DEF_TASK_COUNT;
  localparam int NEVT     = DEF_EVENT_COUNT;
  localparam int NO_TASK  = NTASK;      // end-of-chain marker
  localparam int L_RUN    = 0;
  localparam int L_EVT    = 1;
  localparam int L_TMR    = 2;
  localparam int WDOG_MAX = 5000;       // cycles with no transaction at all
  localparam int RAND_PER_PHASE = 260;

  // how the current task leaves the cpu on a reschedule
  typedef enum int {PARK_AGAIN, PARK_EXIT, PARK_TIMER, PARK_EVENT} park_t;

  typedef struct {
    logic [3:0]  cur;
    logic        acc;
    logic [63:0] tc;
  } sched_res_t;

  // directed row: command plus an optional hand-typed expectation
  typedef struct {
    logic [2:0]  k;
    logic [3:0]  tid;
    logic [31:0] dms;
    logic [3:0]  ev;
    bit          typed;
    logic [3:0]  cur;
    logic        acc;
    logic [63:0] tc;
  } cmd_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [3:0]  fallback_task = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [2:0]  kind = K_TICK;
  logic [3:0]  task_id = '0;
  logic [31:0] delay_ms = '0;
  logic [3:0]  event_id = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [3:0]  current_task;
  logic        accepted;
  logic [63:0] tick_count;

  task_run_queue_scheduler uut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .fallback_task(fallback_task),
    .in_valid(in_valid), .in_stall(in_stall),
    .kind(kind), .task_id(task_id), .delay_ms(delay_ms), .event_id(event_id),
    .out_valid(out_valid), .out_stall(out_stall),
    .current_task(current_task), .accepted(accepted), .tick_count(tick_count)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // scheduler shadow state
  logic [3:0]  sh_idle;
  logic [3:0]  sh_cur;
  logic [63:0] sh_ticks;
  logic [1:0]  sh_memb [NTASK];
  int          sh_next [NTASK];
  int          sh_head [3];
  int          sh_tail [3];
  logic [63:0] sh_wake [NTASK];
  logic [3:0]  sh_wev  [NTASK];
  bit          sh_flag [NEVT];

  sched_res_t pending_results[$];
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int mismatches = 0;
  int wdog = 0;

  function automatic logic [1:0] list_code(int l);
    case (l)
      L_RUN:   return M_RUN;
      L_EVT:   return M_EVT;
      default: return M_TMR;
    endcase
  endfunction

  function automatic int list_of(logic [1:0] code);
    case (code)
      M_RUN:   return L_RUN;
      M_EVT:   return L_EVT;
      default: return L_TMR;
    endcase
  endfunction

  function automatic void shadow_reset();
    sh_idle  = '0;
    sh_cur   = '0;
    sh_ticks = '0;
    for (int i = 0; i < NTASK; i++) begin
      sh_memb[i] = M_FREE;
      sh_next[i] = NO_TASK;
      sh_wake[i] = '0;
      sh_wev[i]  = '0;
    end
    for (int i = 0; i < NEVT; i++) sh_flag[i] = 1'b0;
    for (int l = 0; l < 3; l++) begin
      sh_head[l] = NO_TASK;
      sh_tail[l] = NO_TASK;
    end
  endfunction

  function automatic void append(int l, int t);
    sh_next[t] = NO_TASK;
    if (sh_head[l] == NO_TASK) sh_head[l] = t;
    else sh_next[sh_tail[l]] = t;
    sh_tail[l] = t;
    sh_memb[t] = list_code(l);
  endfunction

  function automatic int take_head(int l);
    int t;
    t = sh_head[l];
    sh_head[l] = sh_next[t];
    if (sh_head[l] == NO_TASK) sh_tail[l] = NO_TASK;
    sh_memb[t] = M_FREE;
    return t;
  endfunction

  function automatic void detach(int t);
    int l;
    int n;
    int prev;
    int steps;
    if (sh_memb[t] == M_FREE) return;
    l = list_of(sh_memb[t]);
    n = sh_head[l];
    prev = NO_TASK;
    steps = 0;
    while (n != NO_TASK && n != t && steps < NTASK) begin
      prev = n;
      n = sh_next[n];
      steps++;
    end
    if (n == t) begin
      if (prev == NO_TASK) sh_head[l] = sh_next[t];
      else sh_next[prev] = sh_next[t];
      if (sh_tail[l] == t) sh_tail[l] = prev;
    end
    sh_memb[t] = M_FREE;
  endfunction

  // sorted insert, after any entry with the same wake time
  function automatic void timer_place(int t);
    int prev;
    int n;
    prev = NO_TASK;
    n = sh_head[L_TMR];
    while (n != NO_TASK && !(sh_wake[n] > sh_wake[t])) begin
      prev = n;
      n = sh_next[n];
    end
    sh_next[t] = n;
    if (prev == NO_TASK) sh_head[L_TMR] = t;
    else sh_next[prev] = t;
    if (n == NO_TASK) sh_tail[L_TMR] = t;
    sh_memb[t] = M_TMR;
  endfunction

  function automatic void reschedule(park_t how, logic [63:0] wake, logic [3:0] ev);
    int t;
    int h;
    t = sh_cur;
    // park the outgoing task; the idle task is never parked
    if (sh_cur != sh_idle) begin
      if (sh_memb[t] != M_FREE) begin
        if (how == PARK_EXIT) detach(t);
      end else if (how == PARK_TIMER) begin
        sh_wake[t] = wake;
        timer_place(t);
      end else if (how == PARK_EVENT) begin
        sh_wev[t] = ev;
        append(L_EVT, t);
      end else if (how == PARK_AGAIN) begin
        append(L_RUN, t);
      end
    end
    // pick: signaled event waiter, then due timer, then runnable, else idle
    h = sh_head[L_EVT];
    if (h != NO_TASK && sh_flag[sh_wev[h]]) begin
      sh_cur = take_head(L_EVT);
      return;
    end
    h = sh_head[L_TMR];
    if (h != NO_TASK && sh_ticks >= sh_wake[h]) begin
      sh_cur = take_head(L_TMR);
      return;
    end
    if (sh_head[L_RUN] != NO_TASK) sh_cur = take_head(L_RUN);
    else sh_cur = sh_idle;
  endfunction

  // waiters of the event go to the front, both groups keep their order
  function automatic void notify_event(int e);
    int mh, mt, rh, rt, n, nx, steps;
    mh = NO_TASK; mt = NO_TASK; rh = NO_TASK; rt = NO_TASK;
    n = sh_head[L_EVT];
    steps = 0;
    sh_flag[e] = 1'b1;
    while (n != NO_TASK && steps < NTASK) begin
      nx = sh_next[n];
      sh_next[n] = NO_TASK;
      if (sh_wev[n] == e) begin
        if (mh == NO_TASK) mh = n; else sh_next[mt] = n;
        mt = n;
      end else begin
        if (rh == NO_TASK) rh = n; else sh_next[rt] = n;
        rt = n;
      end
      n = nx;
      steps++;
    end
    if (mh == NO_TASK) begin
      sh_head[L_EVT] = rh;
      sh_tail[L_EVT] = rt;
    end else begin
      sh_next[mt] = rh;
      sh_head[L_EVT] = mh;
      sh_tail[L_EVT] = (rh == NO_TASK) ? mt : rt;
    end
  endfunction

  function automatic sched_res_t predict_schedule(logic [2:0] k, logic [3:0] tid,
                                                  logic [31:0] dms, logic [3:0] ev);
    sched_res_t r;
    logic acc;
    acc = 1'b0;
    case (k)
      K_TICK: begin
        sh_ticks = sh_ticks + 64'd1;
        reschedule(PARK_AGAIN, '0, '0);
      end
      K_YIELD:  reschedule(PARK_AGAIN, '0, '0);
      K_EXITC:  reschedule(PARK_EXIT, '0, '0);
      K_DELAY:  reschedule(PARK_TIMER, sh_ticks + 64'(dms) / 64'(DEF_MS_PER_TICK), '0);
      K_WAIT:   reschedule(PARK_EVENT, '0, ev);
      K_NOTIFY: notify_event(ev);
      K_RUN: begin
        if (tid != sh_cur && sh_memb[tid] == M_FREE) begin
          append(L_RUN, tid);
          acc = 1'b1;
        end
      end
      default: begin
        if (tid == sh_cur) reschedule(PARK_EXIT, '0, '0);
        else detach(tid);
      end
    endcase
    r.cur = sh_cur;
    r.acc = acc;
    r.tc  = sh_ticks;
    return r;
  endfunction

  // one command transaction; the expectation is queued at acceptance
  task automatic send_cmd(cmd_row_t row);
    sched_res_t r;
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1'b1;
    kind     <= row.k;
    task_id  <= row.tid;
    delay_ms <= row.dms;
    event_id <= row.ev;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    r = predict_schedule(row.k, row.tid, row.dms, row.ev);
    if (row.typed) begin
      r.cur = row.cur;
      r.acc = row.acc;
      r.tc  = row.tc;
    end
    pending_results.push_back(r);
  endtask

  // register write only once every result is back
  task automatic write_idle(logic [3:0] v);
    in_valid <= 1'b0;
    wait (pending_results.size() == 0);
    repeat (8) @(posedge clk);
    cfg_valid     <= 1'b1;
    fallback_task <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    sh_idle = v;
  endtask

  function automatic cmd_row_t row_of(logic [2:0] k, logic [3:0] tid, logic [31:0] dms,
                                      logic [3:0] ev, bit typed, logic [3:0] cur,
                                      logic acc, logic [63:0] tc);
    cmd_row_t row;
    row.k = k; row.tid = tid; row.dms = dms; row.ev = ev;
    row.typed = typed; row.cur = cur; row.acc = acc; row.tc = tc;
    return row;
  endfunction

  // mostly well-formed traffic: plenty of run commands keep the lists busy
  function automatic cmd_row_t random_cmd();
    cmd_row_t row;
    int pick;
    pick = $urandom_range(99);
    if (pick < 25)      row.k = K_RUN;
    else if (pick < 40) row.k = K_TICK;
    else if (pick < 50) row.k = K_YIELD;
    else if (pick < 60) row.k = K_DELAY;
    else if (pick < 72) row.k = K_WAIT;
    else if (pick < 80) row.k = K_NOTIFY;
    else if (pick < 90) row.k = K_EXITT;
    else                row.k = K_EXITC;
    row.tid = 4'($urandom_range(15));
    row.ev  = 4'($urandom_range(15));
    // small delays so tasks come back due; a few huge ones sleep forever
    row.dms = ($urandom_range(9) < 8) ? 32'($urandom_range(60)) : $urandom;
    row.typed = 1'b0;
    row.cur = '0; row.acc = 1'b0; row.tc = '0;
    return row;
  endfunction

  // result checker, receiver stall and watchdog
  always @(posedge clk) begin
    sched_res_t e;
    if (rst) begin
      out_stall <= 1'b0;
      wdog <= 0;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_valid) wdog <= 0;
      else wdog <= wdog + 1;
      if (wdog >= WDOG_MAX) begin
        $display("timeout: no transaction for %0d cycles", WDOG_MAX);
        $display("*** FAILED ***");
        $finish;
      end
      if (out_valid && !out_stall) begin
        if (pending_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result: cur=%0d acc=%0b ticks=%0d",
                     current_task, accepted, tick_count);
        end else begin
          e = pending_results.pop_front();
          if (e.cur !== current_task || e.acc !== accepted || e.tc !== tick_count) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch (exp/got): cur %0d/%0d acc %0b/%0b ticks %0d/%0d",
                       e.cur, current_task, e.acc, accepted, e.tc, tick_count);
          end
        end
      end
    end
  end

  cmd_row_t directed[$];

  initial begin
    int phase_idle [3];
    int phase_send [3];
    int phase_recv [3];
    shadow_reset();
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // idle task at extremes and one in the middle
    phase_idle = '{0, 15, 9};
    phase_send = '{22, 73, 0};
    phase_recv = '{73, 22, 0};

    // directed walk from reset, idle task 0
    directed.push_back(row_of(K_TICK,   4'd0,  32'd0, 4'd0,  1, 4'd0, 1'b0, 64'd1));
    directed.push_back(row_of(K_RUN,    4'd3,  32'd0, 4'd0,  1, 4'd0, 1'b1, 64'd1));
    // already queued, then the current task: both refused
    directed.push_back(row_of(K_RUN,    4'd3,  32'd0, 4'd0,  1, 4'd0, 1'b0, 64'd1));
    directed.push_back(row_of(K_RUN,    4'd0,  32'd0, 4'd0,  1, 4'd0, 1'b0, 64'd1));
    directed.push_back(row_of(K_YIELD,  4'd0,  32'd0, 4'd0,  1, 4'd3, 1'b0, 64'd1));
    directed.push_back(row_of(K_RUN,    4'd5,  32'd0, 4'd0,  1, 4'd3, 1'b1, 64'd1));
    // longest delay: task 3 sleeps far away
    directed.push_back(row_of(K_DELAY,  4'd0,  32'hFFFF_FFFF, 4'd0, 1, 4'd5, 1'b0, 64'd1));
    directed.push_back(row_of(K_WAIT,   4'd0,  32'd0, 4'd15, 1, 4'd0, 1'b0, 64'd1));
    directed.push_back(row_of(K_NOTIFY, 4'd0,  32'd0, 4'd15, 1, 4'd0, 1'b0, 64'd1));
    directed.push_back(row_of(K_YIELD,  4'd0,  32'd0, 4'd0,  1, 4'd5, 1'b0, 64'd1));
    directed.push_back(row_of(K_EXITC,  4'd0,  32'd0, 4'd0,  1, 4'd0, 1'b0, 64'd1));
    // sleeping task taken off the timer list, then exit of a free task
    directed.push_back(row_of(K_EXITT,  4'd3,  32'd0, 4'd0,  1, 4'd0, 1'b0, 64'd1));
    directed.push_back(row_of(K_EXITT,  4'd9,  32'd0, 4'd0,  1, 4'd0, 1'b0, 64'd1));
    directed.push_back(row_of(K_RUN,    4'd9,  32'd0, 4'd0,  1, 4'd0, 1'b1, 64'd1));
    directed.push_back(row_of(K_RUN,    4'd15, 32'd0, 4'd0,  1, 4'd0, 1'b1, 64'd1));
    directed.push_back(row_of(K_EXITT,  4'd15, 32'd0, 4'd0,  1, 4'd0, 1'b0, 64'd1));
    directed.push_back(row_of(K_TICK,   4'd0,  32'd0, 4'd0,  1, 4'd9, 1'b0, 64'd2));
    // zero delay is due at once
    directed.push_back(row_of(K_DELAY,  4'd0,  32'd0, 4'd0,  1, 4'd9, 1'b0, 64'd2));
    directed.push_back(row_of(K_WAIT,   4'd0,  32'd0, 4'd0,  1, 4'd0, 1'b0, 64'd2));
    // exit of the idle task while it runs: never parked
    directed.push_back(row_of(K_EXITT,  4'd0,  32'd0, 4'd0,  1, 4'd0, 1'b0, 64'd2));
    directed.push_back(row_of(K_NOTIFY, 4'd0,  32'd0, 4'd0,  1, 4'd0, 1'b0, 64'd2));
    directed.push_back(row_of(K_YIELD,  4'd0,  32'd0, 4'd0,  1, 4'd9, 1'b0, 64'd2));
    directed.push_back(row_of(K_DELAY,  4'd0,  32'd9, 4'd0,  1, 4'd9, 1'b0, 64'd2));
    directed.push_back(row_of(K_DELAY,  4'd0,  32'd25, 4'd0, 0, 4'd0, 1'b0, 64'd0));
    directed.push_back(row_of(K_TICK,   4'd0,  32'd0, 4'd0,  0, 4'd0, 1'b0, 64'd0));

    for (int p = 0; p < 3; p++) begin
      send_idle_pct = phase_send[p];
      recv_idle_pct = phase_recv[p];
      write_idle(4'(phase_idle[p]));
      if (p == 0)
        foreach (directed[i]) send_cmd(directed[i]);
      for (int i = 0; i < RAND_PER_PHASE; i++) send_cmd(random_cmd());
    end
    in_valid <= 1'b0;

    wait (pending_results.size() == 0);
    repeat (40) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/trqs_pkg.sv
rtl/trqs_cell.sv
rtl/trqs_chain.sv
rtl/task_run_queue_scheduler.sv
tb/tb_task_run_queue_scheduler.sv
